/* hdl/orientational_pair_correlation_macros.svh */
// assertion macros for the orientational pair correlation block
// used by files that check their own control logic; needs clk and arst_n in scope
`ifndef ORIENTATIONAL_PAIR_CORRELATION_MACROS_SVH
`define ORIENTATIONAL_PAIR_CORRELATION_MACROS_SVH

// same-cycle implication
`define OPC_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define OPC_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/opc_pkg.sv */
// shared types, codes and the quarter-wave sine table for the g6 histogram
// no dependencies
package opc_pkg;

	localparam int MAX_BONDS   = 4096;
	localparam int BINS        = 4096;
	localparam int TABLE_DEPTH = 1024;
	localparam int BOND_AW     = 12;
	localparam int BIN_AW      = 12;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_COMPUTE = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	localparam logic [1:0] KIND_LOADED = 2'd0;
	localparam logic [1:0] KIND_REJECT = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;
	localparam logic [1:0] KIND_BIN    = 2'd3;

	localparam logic [22:0] PAIRS_MAX = 23'h7FFFFF;
	localparam logic signed [55:0] SUM_MAX = {1'b0, {55{1'b1}}};
	localparam logic signed [55:0] SUM_MIN = {1'b1, {55{1'b0}}};

	typedef logic [63:0] u64_t;
	typedef logic [14:0] qtab_t [0:TABLE_DEPTH];

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [15:0] c;
		logic signed [15:0] s;
	} bond_t;

	typedef struct packed {
		logic signed [55:0] sum;
		logic [22:0]        pairs;
	} hist_t;

	localparam u64_t HALF_PI_Q30 = 64'd1686629713;

	// shift and subtract quotient, used only while the table is elaborated
	function automatic u64_t div_c(u64_t num, u64_t den);
		u64_t quo;
		u64_t rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin over a quarter turn, taylor series in q30, rounded to q15
	function automatic qtab_t build_qtab();
		qtab_t t;
		u64_t x;
		u64_t x2;
		u64_t term;
		u64_t qv;
		longint s;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			x = (u64_t'(k) * HALF_PI_Q30) >> 10;
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = div_c((term * x2) >> 30, u64_t'((2 * n) * (2 * n + 1)));
				if ((n & 1) == 1) s = s - longint'(term);
				else s = s + longint'(term);
			end
			if (s < 0) s = 0;
			qv = (u64_t'(s) + 64'd16384) >> 15;
			if (qv > 64'd32767) qv = 64'd32767;
			t[k] = qv[14:0];
		end
		return t;
	endfunction

endpackage

/* hdl/orientational_pair_correlation.sv */
// top level of the bond orientational (g6) pair correlation histogram
// depends on opc_pkg, opc_ram, opc_trig, opc_sqrt, opc_div and the macro header
//
// Input items arrive on s_tvalid/s_tready with the command in s_tuser; each
// command except a clear of the bond store returns one item on m_tvalid/m_tready.
// A bond load stores the position with cos/sin of six times the angle, which
// come from a registered quarter-wave rom. A bin read of a non-empty bin also
// waits for the bit-serial mean divider; an empty bin skips it.
// A compute command first sweeps the 4096 histogram entries to zero, then walks
// every strided pair i<j: each pair waits for the one-bit-per-cycle square root
// of the squared distance, and pairs farther than the last bin skip the root.
// Bonds and the histogram sit in single-write, single-read memories, and a pair
// finishes its histogram read-modify-write before the next pair starts.
// After reset the block runs the same clearing sweep over all 4096 entries with
// s_tready low; the stride register can be written at any time while idle.
// Results go to an output register: one finished item may wait there while
// the next command is accepted, and the block stalls only when a second
// result is ready before the first has been taken.
`include "orientational_pair_correlation_macros.svh"
module orientational_pair_correlation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         stride_we,
	input  logic [12:0]  stride_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_pos[23:0], y_pos[47:24], angle[63:48], bin_index[75:64], zero pad
	input  logic [79:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bin_out[11:0], pair_count[34:12], corr_sum[90:35], mean_corr[106:91],
	// bonds_loaded[119:107]
	output logic [119:0] m_tdata,
	// kind[1:0]
	output logic [1:0]   m_tuser
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_RDI  = 4'd3;
	localparam logic [3:0] ST_LATI = 4'd4;
	localparam logic [3:0] ST_RDJ  = 4'd5;
	localparam logic [3:0] ST_DIFF = 4'd6;
	localparam logic [3:0] ST_SQR  = 4'd7;
	localparam logic [3:0] ST_ADD  = 4'd8;
	localparam logic [3:0] ST_SQS  = 4'd9;
	localparam logic [3:0] ST_SQW  = 4'd10;
	localparam logic [3:0] ST_HR   = 4'd11;
	localparam logic [3:0] ST_RD   = 4'd12;
	localparam logic [3:0] ST_DIVW = 4'd13;
	localparam logic [3:0] ST_RESP = 4'd14;

	logic [3:0]  state_q;
	logic [12:0] stride_q;
	logic [12:0] count_q;
	logic        clr_cmp_q;
	logic [11:0] clr_addr_q;
	logic [13:0] i_q;
	logic [13:0] j_q;
	logic [11:0] bin_q;

	logic signed [23:0] ld_x_q;
	logic signed [23:0] ld_y_q;
	opc_pkg::bond_t bi_q;

	logic signed [24:0] dx_s1;
	logic signed [24:0] dy_s1;
	logic signed [31:0] cc_s1;
	logic signed [31:0] ss_s1;
	logic [49:0]        dxx_s2;
	logic [49:0]        dyy_s2;
	logic signed [32:0] prod_s2;
	logic [50:0]        sq_s3;

	logic [1:0]         resp_kind_q;
	logic [11:0]        resp_bin_q;
	logic [22:0]        resp_cnt_q;
	logic signed [55:0] resp_sum_q;
	logic signed [15:0] resp_mean_q;

	logic               m_tvalid_q;
	logic [119:0]       m_tdata_q;
	logic [1:0]         m_tuser_q;

	logic        accept;
	logic [1:0]  in_cmd;
	logic [11:0] in_bin;
	logic [12:0] st_eff;
	logic [13:0] count14;
	logic [13:0] row_nx;
	logic [13:0] j_nx;
	logic        row_end;
	logic        j_end;
	logic        out_free;

	logic signed [15:0] trig_c;
	logic signed [15:0] trig_s;

	logic                bond_we;
	logic [11:0]         bond_raddr;
	opc_pkg::bond_t      bond_wr;
	opc_pkg::bond_t      bond_rd;
	logic [79:0]         bond_rdata;

	logic                hist_we;
	logic [11:0]         hist_waddr;
	logic [11:0]         hist_raddr;
	opc_pkg::hist_t      hist_wr;
	opc_pkg::hist_t      hist_upd;
	opc_pkg::hist_t      hist_rd;
	logic [78:0]         hist_rdata;
	logic signed [56:0]  sum_nx;
	logic signed [55:0]  sum_sat;
	logic [22:0]         pairs_nx;

	logic        sqrt_start;
	logic        sqrt_done;
	logic [19:0] sqrt_root;
	logic        div_start;
	logic        div_done;
	logic signed [15:0] div_mean;

	assign in_cmd   = s_tuser;
	assign in_bin   = s_tdata[75:64];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// a stride of zero walks like a stride of one
	assign st_eff  = (stride_q == 13'd0) ? 13'd1 : stride_q;
	assign count14 = {1'b0, count_q};
	assign row_nx  = i_q + {1'b0, st_eff};
	assign j_nx    = j_q + {1'b0, st_eff};
	assign row_end = row_nx >= count14;
	assign j_end   = j_nx >= count14;

	opc_trig u_trig (
		.clk   (clk),
		.angle (s_tdata[63:48]),
		.cos6  (trig_c),
		.sin6  (trig_s)
	);

	assign bond_we    = (state_q == ST_LOAD);
	assign bond_wr    = '{x: ld_x_q, y: ld_y_q, c: trig_c, s: trig_s};
	assign bond_raddr = (state_q == ST_RDJ) ? j_q[11:0] : i_q[11:0];
	assign bond_rd    = opc_pkg::bond_t'(bond_rdata);

	opc_ram #(.W(80), .AW(opc_pkg::BOND_AW)) u_bond_ram (
		.clk   (clk),
		.we    (bond_we),
		.waddr (count_q[11:0]),
		.wdata (bond_wr),
		.raddr (bond_raddr),
		.rdata (bond_rdata)
	);

	assign hist_rd  = opc_pkg::hist_t'(hist_rdata);
	assign sum_nx   = {hist_rd.sum[55], hist_rd.sum} + {{24{prod_s2[32]}}, prod_s2};
	always_comb begin
		if (sum_nx[56] != sum_nx[55]) begin
			sum_sat = sum_nx[56] ? opc_pkg::SUM_MIN : opc_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_nx[55:0];
		end
	end
	assign pairs_nx = (hist_rd.pairs == opc_pkg::PAIRS_MAX) ? hist_rd.pairs
		: hist_rd.pairs + 23'd1;

	assign hist_upd   = '{sum: sum_sat, pairs: pairs_nx};
	assign hist_we    = (state_q == ST_CLR) || (state_q == ST_HR);
	assign hist_waddr = (state_q == ST_CLR) ? clr_addr_q : bin_q;
	assign hist_wr    = (state_q == ST_CLR) ? 79'd0 : hist_upd;
	assign hist_raddr = (state_q == ST_IDLE) ? in_bin : sqrt_root[19:8];

	opc_ram #(.W(79), .AW(opc_pkg::BIN_AW)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wr),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// pairs beyond the last bin (distance^2 >= 2^40) skip the root
	assign sqrt_start = (state_q == ST_SQS) && (sq_s3[50:40] == 11'd0);

	opc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.val    (sq_s3[39:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign div_start = (state_q == ST_RD) && (hist_rd.pairs != 23'd0);

	opc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum_in (hist_rd.sum),
		.cnt_in (hist_rd.pairs),
		.done   (div_done),
		.mean   (div_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			stride_q   <= 13'd4;
			count_q    <= '0;
			clr_cmp_q  <= 1'b0;
			clr_addr_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
		end else begin
			if (stride_we) begin
				stride_q <= stride_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							opc_pkg::CMD_LOAD: begin
								if (count_q == 13'(opc_pkg::MAX_BONDS)) state_q <= ST_RESP;
								else state_q <= ST_LOAD;
							end
							opc_pkg::CMD_COMPUTE: begin
								clr_cmp_q  <= 1'b1;
								clr_addr_q <= '0;
								state_q    <= ST_CLR;
							end
							opc_pkg::CMD_READ: begin
								state_q <= ST_RD;
							end
							default: begin
								count_q <= '0;
							end
						endcase
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 12'd1;
					if (clr_addr_q == 12'(opc_pkg::BINS - 1)) begin
						clr_cmp_q <= 1'b0;
						i_q       <= '0;
						if (!clr_cmp_q) state_q <= ST_IDLE;
						else if (count_q == 13'd0) state_q <= ST_RESP;
						else state_q <= ST_RDI;
					end
				end
				ST_LOAD: begin
					count_q <= count_q + 13'd1;
					state_q <= ST_RESP;
				end
				ST_RDI: begin
					state_q <= ST_LATI;
				end
				ST_LATI: begin
					if (row_end) begin
						state_q <= ST_RESP;
					end else begin
						j_q     <= row_nx;
						state_q <= ST_RDJ;
					end
				end
				ST_RDJ: state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_ADD;
				ST_ADD: state_q <= ST_SQS;
				ST_SQS, ST_HR: begin
					if (state_q == ST_SQS && sqrt_start) begin
						state_q <= ST_SQW;
					end else if (!j_end) begin
						j_q     <= j_nx;
						state_q <= ST_RDJ;
					end else if (row_end) begin
						state_q <= ST_RESP;
					end else begin
						i_q     <= row_nx;
						state_q <= ST_RDI;
					end
				end
				ST_SQW: begin
					if (sqrt_done) state_q <= ST_HR;
				end
				ST_RD: begin
					if (div_start) state_q <= ST_DIVW;
					else state_q <= ST_RESP;
				end
				ST_DIVW: begin
					if (div_done) state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_x_q      <= s_tdata[23:0];
			ld_y_q      <= s_tdata[47:24];
			resp_bin_q  <= '0;
			resp_cnt_q  <= '0;
			resp_sum_q  <= '0;
			resp_mean_q <= '0;
			case (in_cmd)
				opc_pkg::CMD_LOAD: begin
					if (count_q == 13'(opc_pkg::MAX_BONDS)) resp_kind_q <= opc_pkg::KIND_REJECT;
					else resp_kind_q <= opc_pkg::KIND_LOADED;
				end
				opc_pkg::CMD_COMPUTE: resp_kind_q <= opc_pkg::KIND_DONE;
				default: begin
					resp_kind_q <= opc_pkg::KIND_BIN;
					resp_bin_q  <= in_bin;
				end
			endcase
		end
		if (state_q == ST_LATI) begin
			bi_q <= bond_rd;
		end
		if (state_q == ST_DIFF) begin
			dx_s1 <= {bi_q.x[23], bi_q.x} - {bond_rd.x[23], bond_rd.x};
			dy_s1 <= {bi_q.y[23], bi_q.y} - {bond_rd.y[23], bond_rd.y};
			cc_s1 <= bi_q.c * bond_rd.c;
			ss_s1 <= bi_q.s * bond_rd.s;
		end
		if (state_q == ST_SQR) begin
			dxx_s2  <= 50'(dx_s1 * dx_s1);
			dyy_s2  <= 50'(dy_s1 * dy_s1);
			prod_s2 <= {cc_s1[31], cc_s1} + {ss_s1[31], ss_s1};
		end
		if (state_q == ST_ADD) begin
			sq_s3 <= {1'b0, dxx_s2} + {1'b0, dyy_s2};
		end
		if (state_q == ST_SQW && sqrt_done) begin
			bin_q <= sqrt_root[19:8];
		end
		if (state_q == ST_RD) begin
			resp_cnt_q <= hist_rd.pairs;
			resp_sum_q <= hist_rd.sum;
		end
		if (state_q == ST_DIVW && div_done) begin
			resp_mean_q <= div_mean;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_tuser_q <= resp_kind_q;
			m_tdata_q <= {count_q, resp_mean_q, resp_sum_q, resp_cnt_q, resp_bin_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`OPC_ASSERT_IMP(a_count_max, 1'b1, count_q <= 13'(opc_pkg::MAX_BONDS), "bond count beyond store depth")
	`OPC_ASSERT_NXT(a_load_count, state_q == ST_LOAD, count_q == $past(count_q) + 13'd1, "load did not advance count")
	`OPC_ASSERT_IMP(a_sqrt_owner, sqrt_done, state_q == ST_SQW, "root finished while control not waiting")
	`OPC_ASSERT_IMP(a_div_owner, div_done, state_q == ST_DIVW, "mean finished while control not waiting")

endmodule

/* hdl/opc_ram.sv */
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module opc_ram #(
	parameter int W  = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [0:(1 << AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/opc_trig.sv */
// cos and sin of six times the angle from a registered quarter-wave rom
// depends on opc_pkg for the table and its depth
module opc_trig (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [15:0] cos6,
	output logic signed [15:0] sin6
);

	localparam opc_pkg::qtab_t QTAB = opc_pkg::build_qtab();

	logic [17:0] p_wide;
	logic [15:0] phase;
	logic [9:0]  r;
	logic [1:0]  quad_q;
	logic [14:0] a_q;
	logic [14:0] b_q;
	logic signed [15:0] a;
	logic signed [15:0] b;

	// angle * 6 modulo one turn
	assign p_wide = {angle, 2'b00} + {1'b0, angle, 1'b0};
	assign phase  = p_wide[15:0];
	assign r      = phase[13:4];

	always_ff @(posedge clk) begin
		a_q    <= QTAB[r];
		b_q    <= QTAB[11'(opc_pkg::TABLE_DEPTH) - {1'b0, r}];
		quad_q <= phase[15:14];
	end

	assign a = {1'b0, a_q};
	assign b = {1'b0, b_q};

	always_comb begin
		case (quad_q)
			2'd0: begin
				sin6 = a;
				cos6 = b;
			end
			2'd1: begin
				sin6 = b;
				cos6 = -a;
			end
			2'd2: begin
				sin6 = -a;
				cos6 = -b;
			end
			default: begin
				sin6 = -b;
				cos6 = a;
			end
		endcase
	end

endmodule

/* hdl/opc_sqrt.sv */
// iterative integer square root, one root bit per cycle
// no dependencies
module opc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] val,
	output logic        done,
	output logic [19:0] root
);

	logic [39:0] src_q;
	logic [21:0] rem_q;
	logic [19:0] root_q;
	logic [4:0]  step_q;
	logic        run_q;
	logic        done_q;
	logic [23:0] rem_n;
	logic [23:0] trial;

	assign rem_n = {rem_q, src_q[39:38]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 5'd20;
			end else if (run_q) begin
				step_q <= step_q - 5'd1;
				if (step_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			src_q <= {src_q[37:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= 22'(rem_n - trial);
				root_q <= {root_q[18:0], 1'b1};
			end else begin
				rem_q  <= rem_n[21:0];
				root_q <= {root_q[18:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hdl/opc_div.sv */
// bin mean: rounded |sum| / (pairs * 2^15) with the sign of sum, saturated;
// restoring divide one bit per cycle; no dependencies
module opc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [55:0] sum_in,
	input  logic [22:0]        cnt_in,
	output logic               done,
	output logic signed [15:0] mean
);

	logic [55:0] mag;
	logic [37:0] den;
	logic [56:0] num;
	logic [56:0] rem_q;
	logic [53:0] dv_q;
	logic [16:0] quo_q;
	logic        neg_q;
	logic        ovf_q;
	logic [4:0]  step_q;
	logic        run_q;
	logic        done_q;

	assign mag = sum_in[55] ? 56'(-sum_in) : 56'(sum_in);
	assign den = {cnt_in, 15'd0};
	assign num = {1'b0, mag} + {20'd0, den[37:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= 5'd17;
			end else if (run_q) begin
				step_q <= step_q - 5'd1;
				if (step_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= sum_in[55];
			// quotient of 2^17 or more saturates either way
			ovf_q <= num >= {2'b00, den, 17'd0};
			rem_q <= num;
			dv_q  <= {den, 16'd0};
			quo_q <= '0;
		end else if (run_q) begin
			dv_q <= {1'b0, dv_q[53:1]};
			if (rem_q >= {3'b000, dv_q}) begin
				rem_q <= rem_q - {3'b000, dv_q};
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if (ovf_q || quo_q > 17'd32768) mean = 16'sh8000;
			else mean = 16'(-quo_q);
		end else begin
			if (ovf_q || quo_q > 17'd32767) mean = 16'sh7FFF;
			else mean = 16'(quo_q);
		end
	end

	assign done = done_q;

endmodule

/* sim/tb_orientational_pair_correlation.sv */
// self-checking testbench for the g6 pair correlation histogram block
// depends on opc_pkg and orientational_pair_correlation; items are predicted in-bench
module tb_orientational_pair_correlation;
	import opc_pkg::*;

	typedef struct {
		logic [1:0]         kind;
		logic [11:0]        bin;
		logic [22:0]        pairs;
		logic signed [55:0] sum;
		logic signed [15:0] mean;
		logic [12:0]        bonds;
	} g6_result_t;

	typedef struct {
		logic [1:0]         cmd;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0]        angle;
		logic [11:0]        bin;
		bit                 typed;
		logic [1:0]         kind;
		logic [12:0]        bonds;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         stride_we;
	logic [12:0]  stride_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [79:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;

	orientational_pair_correlation uut (
		.clk(clk), .arst_n(arst_n),
		.stride_we(stride_we), .stride_wdata(stride_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// predictor state
	int                 sine_q15 [0:TABLE_DEPTH];
	int                 px [0:MAX_BONDS-1];
	int                 py [0:MAX_BONDS-1];
	int                 pc [0:MAX_BONDS-1];
	int                 ps [0:MAX_BONDS-1];
	longint             hsum [0:BINS-1];
	int                 hpairs [0:BINS-1];
	int                 bond_count;
	int                 stride_reg;

	g6_result_t pending_results [$];
	int  errors;
	longint cycles;
	bit  quiet;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 4000000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic build_sine();
		longint unsigned x, x2, term, q;
		longint s;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			x = (longint'(k) * 64'd1686629713) / TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			s = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2) s = s - longint'(term);
				else s = s + longint'(term);
			end
			if (s < 0) s = 0;
			q = (longint'(s) + 16384) >> 15;
			if (q > 32767) q = 32767;
			sine_q15[k] = int'(q);
		end
	endtask

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic build_histogram();
		int st;
		longint dx, dy, prod, ns;
		longint unsigned d;
		st = (stride_reg == 0) ? 1 : stride_reg;
		for (int b = 0; b < BINS; b++) begin
			hsum[b] = 0;
			hpairs[b] = 0;
		end
		for (int i = 0; i < bond_count; i += st)
			for (int j = i + st; j < bond_count; j += st) begin
				dx = longint'(px[i]) - px[j];
				dy = longint'(py[i]) - py[j];
				d = int_sqrt(dx * dx + dy * dy) >> 8;
				if (d < BINS) begin
					prod = longint'(pc[i]) * pc[j] + longint'(ps[i]) * ps[j];
					ns = hsum[d] + prod;
					if (ns > longint'(SUM_MAX)) ns = SUM_MAX;
					if (ns < longint'(SUM_MIN)) ns = SUM_MIN;
					hsum[d] = ns;
					if (hpairs[d] < int'(PAIRS_MAX)) hpairs[d]++;
				end
			end
	endtask

	// advance the predictor by one item; returns 0 when no result follows
	task automatic predict_g6(input stim_row_t it, output bit has_res, output g6_result_t r);
		int p, idx, q, rr, a, b, sn, cs;
		longint unsigned mag, den, m;
		longint sm;
		r = '{default: '0};
		has_res = 1;
		case (it.cmd)
			CMD_CLEAR: begin
				bond_count = 0;
				has_res = 0;
			end
			CMD_LOAD: begin
				if (bond_count < MAX_BONDS) begin
					p = (int'(it.angle) * 6) & 16'hFFFF;
					idx = p >> 4;
					q = idx / TABLE_DEPTH;
					rr = idx % TABLE_DEPTH;
					a = sine_q15[rr];
					b = sine_q15[TABLE_DEPTH - rr];
					case (q)
						0: begin sn = a; cs = b; end
						1: begin sn = b; cs = -a; end
						2: begin sn = -a; cs = -b; end
						default: begin sn = -b; cs = a; end
					endcase
					px[bond_count] = it.x;
					py[bond_count] = it.y;
					pc[bond_count] = cs;
					ps[bond_count] = sn;
					bond_count++;
					r.kind = KIND_LOADED;
				end else r.kind = KIND_REJECT;
			end
			CMD_COMPUTE: begin
				build_histogram();
				r.kind = KIND_DONE;
			end
			default: begin
				r.kind = KIND_BIN;
				r.bin = it.bin;
				sm = hsum[it.bin];
				r.pairs = hpairs[it.bin];
				r.sum = sm;
				if (hpairs[it.bin] != 0) begin
					mag = (sm < 0) ? longint'(-sm) : longint'(sm);
					den = longint'(hpairs[it.bin]) << 15;
					m = (mag + (den >> 1)) / den;
					if (sm < 0) r.mean = (m > 32768) ? -32768 : -longint'(m);
					else r.mean = (m > 32767) ? 32767 : longint'(m);
				end
			end
		endcase
		r.bonds = bond_count;
	endtask

	// offer one item; valid stays high afterwards unless the caller idles
	task automatic send_item(input stim_row_t it);
		bit has_res;
		g6_result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {4'b0, it.bin, it.angle, it.y, it.x};
		do @(posedge clk); while (!s_tready);
		predict_g6(it, has_res, r);
		if (it.typed) begin
			r = '{default: '0};
			r.kind = it.kind;
			r.bonds = it.bonds;
			if (it.cmd == CMD_READ) r.bin = it.bin;
		end
		if (has_res) pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_stride(input int v);
		drain();
		stride_we <= 1'b1;
		stride_wdata <= v[12:0];
		@(negedge clk);
		stride_we <= 1'b0;
		stride_reg = v & 16'h1FFF;
	endtask

	function automatic stim_row_t mk(input logic [1:0] cmd, input int x = 0, input int y = 0,
			input int angle = 0, input int bin = 0);
		stim_row_t it;
		it = '{default: '0};
		it.cmd = cmd;
		it.x = x;
		it.y = y;
		it.angle = angle;
		it.bin = bin;
		return it;
	endfunction

	function automatic stim_row_t typed_row(input logic [1:0] cmd, input int bin,
			input logic [1:0] kind, input int bonds);
		stim_row_t it;
		it = mk(cmd, 0, 0, 0, bin);
		it.typed = 1;
		it.kind = kind;
		it.bonds = bonds;
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		g6_result_t e;
		g6_result_t a;
		if (arst_n && m_tvalid && m_tready) begin
			a.kind = m_tuser;
			a.bin = m_tdata[11:0];
			a.pairs = m_tdata[34:12];
			a.sum = m_tdata[90:35];
			a.mean = m_tdata[106:91];
			a.bonds = m_tdata[119:107];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item kind %0d", $time, a.kind);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (a.kind !== e.kind || a.bin !== e.bin || a.pairs !== e.pairs ||
						a.sum !== e.sum || a.mean !== e.mean || a.bonds !== e.bonds) begin
					$display("%0t: mismatch exp kind %0d bin %0d pairs %0d sum %0d mean %0d bonds %0d",
						$time, e.kind, e.bin, e.pairs, e.sum, e.mean, e.bonds);
					$display("%0t:          got kind %0d bin %0d pairs %0d sum %0d mean %0d bonds %0d",
						$time, a.kind, a.bin, a.pairs, a.sum, a.mean, a.bonds);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready <= 1'b1;
			end else m_tready <= 1'b1;
		end
	end

	initial begin
		stim_row_t directed [$];
		stim_row_t it;
		int n, nreads, span;
		errors = 0;
		cycles = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 1'b0;
		stride_we = 1'b0;
		stride_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		build_sine();
		for (int b = 0; b < BINS; b++) begin
			hsum[b] = 0;
			hpairs[b] = 0;
		end
		bond_count = 0;
		stride_reg = 4;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		while (!s_tready) @(negedge clk);

		// directed: empty histogram, extremes of position and angle, default stride
		directed.push_back(typed_row(CMD_READ, 0, KIND_BIN, 0));
		directed.push_back(typed_row(CMD_READ, 4095, KIND_BIN, 0));
		directed.push_back(typed_row(CMD_COMPUTE, 0, KIND_DONE, 0));
		directed.push_back(mk(CMD_LOAD, 0, 0, 0));
		directed.push_back(mk(CMD_LOAD, 8388607, -8388608, 16'hFFFF));
		directed.push_back(typed_row(CMD_CLEAR, 0, KIND_LOADED, 0));
		directed.push_back(mk(CMD_LOAD, 0, 0, 16'h0000));
		directed.push_back(mk(CMD_LOAD, 100, 0, 16'h2AAB));
		directed.push_back(mk(CMD_LOAD, -8388608, 8388607, 16'h8000));
		directed.push_back(mk(CMD_LOAD, 8388607, 8388607, 16'h5555));
		directed.push_back(mk(CMD_LOAD, 300, -200, 16'h1555));
		directed.push_back(mk(CMD_LOAD, 1, 1, 16'hAAAA));
		directed.push_back(mk(CMD_LOAD, -256, 512, 16'h0AAB));
		directed.push_back(mk(CMD_LOAD, 0, 0, 16'hFFFF));
		directed.push_back(mk(CMD_LOAD, 700, 900, 16'h4000));
		directed.push_back(mk(CMD_COMPUTE));
		for (int b = 0; b < 5; b++) directed.push_back(mk(CMD_READ, 0, 0, 0, b));
		directed.push_back(mk(CMD_READ, 0, 0, 0, 4095));
		foreach (directed[k]) begin
			// a clear gives no item, so the typed fields there are unused
			if (directed[k].cmd == CMD_CLEAR) directed[k].typed = 0;
			send_item(directed[k]);
		end

		// stride zero acts as one
		write_stride(0);
		send_item(mk(CMD_COMPUTE));
		for (int b = 0; b < 6; b++) send_item(mk(CMD_READ, 0, 0, 0, b));

		// fill the bond store and overflow it, then the widest stride values
		write_stride(1);
		send_item(mk(CMD_CLEAR));
		for (int k = 0; k < MAX_BONDS; k++)
			send_item(mk(CMD_LOAD, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
				$urandom_range(0, 65535)));
		send_item(mk(CMD_LOAD, 5, 5, 5));
		write_stride(4096);
		send_item(mk(CMD_COMPUTE));
		write_stride(2048);
		send_item(mk(CMD_COMPUTE));
		for (int b = 0; b < 24; b++) send_item(mk(CMD_READ, 0, 0, 0, b));
		write_stride(8191);
		send_item(mk(CMD_COMPUTE));
		send_item(mk(CMD_READ, 0, 0, 0, 0));
		send_item(mk(CMD_CLEAR));

		// back pressure: output held off while loads keep coming
		hold_req = 1;
		for (int k = 0; k < 12; k++) send_item(mk(CMD_LOAD, k * 300, 0, k * 4000));
		while (hold_req) @(negedge clk);

		// random sequences: stride writes, clear, loads, compute, bin reads, with noise
		n = 0;
		while (n < 650) begin
			if (n > 560) quiet = 1;
			if ($urandom_range(0, 3) == 0) write_stride($urandom_range(0, 9) == 0 ?
				$urandom_range(0, 8191) : $urandom_range(1, 4));
			if (bond_count > 8 || $urandom_range(0, 2) == 0) begin
				send_item(mk(CMD_CLEAR));
				n++;
			end
			span = ($urandom_range(0, 4) == 0) ? 8388607 : 3000;
			repeat ($urandom_range(2, 14)) begin
				if (span == 8388607)
					send_item(mk(CMD_LOAD, $urandom, $urandom, $urandom_range(0, 65535)));
				else
					send_item(mk(CMD_LOAD, $urandom_range(0, 2 * span) - span,
						$urandom_range(0, 2 * span) - span, $urandom_range(0, 65535)));
				n++;
			end
			send_item(mk(CMD_COMPUTE));
			n++;
			nreads = $urandom_range(3, 10);
			repeat (nreads) begin
				send_item(mk(CMD_READ, 0, 0, 0, $urandom_range(0, 7) == 0 ?
					$urandom_range(0, 4095) : $urandom_range(0, 24)));
				n++;
			end
			// noise: any command with any field values, computes kept cheap
			if ($urandom_range(0, 2) == 0) begin
				it = mk($urandom_range(0, 3), $urandom, $urandom, $urandom_range(0, 65535),
					$urandom_range(0, 4095));
				if (it.cmd == CMD_COMPUTE && bond_count > 20) it.cmd = CMD_READ;
				send_item(it);
				n++;
			end
		end

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
